[hdl/gspt_pkg.sv]
// ----------------------------------------------------------------------------
// gspt_pkg: shared types and constants for the graph search path tracer
// Beat layouts, opcodes, controller state codes and the lane control group.
// ----------------------------------------------------------------------------
package gspt_pkg;

    // default vertex count of the adjacency matrix
    localparam int VERTICES_DEF = 16;

    // fixed field widths of the beats
    localparam int VIDX_W = 4;
    localparam int ROW_W  = 16;
    localparam int HOP_W  = 4;

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // input beat
    typedef struct packed {
        logic              opcode;
        logic [VIDX_W-1:0] row_index;
        logic [ROW_W-1:0]  row_bits;
        logic [VIDX_W-1:0] start_vertex;
        logic [VIDX_W-1:0] end_vertex;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [VIDX_W-1:0] path_vertex;
        logic [HOP_W-1:0]  hop_count;
        logic              reachable;
        logic              last;
    } out_beat_t;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PICK  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_POP   = 6'b001000,
        ST_TRACE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // control group from the sequencer to every vertex lane
    typedef struct packed {
        logic init;   // new search: clear marks, seed the start vertex
        logic scan;   // neighbor row of the current vertex is on row_bit
    } lane_ctl_t;

endpackage

[hdl/gspt_ram.sv]
// ----------------------------------------------------------------------------
// gspt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/gspt_lane.sv]
// ----------------------------------------------------------------------------
// gspt_lane: per-vertex search lane
// Holds the visited mark, tree parent and hop count of one vertex and flags
// the vertex as freshly discovered while the current row is scanned.
// ----------------------------------------------------------------------------
module gspt_lane #(
    parameter int VW      = 4,
    parameter int LANE_ID = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gspt_pkg::lane_ctl_t        ctl,
    input  logic [VW-1:0]              vtx,      // start on init, current on scan
    input  logic [gspt_pkg::HOP_W-1:0] hop_wr,
    input  logic                       row_bit,
    output logic                       mark,
    output logic                       fresh,
    output logic [VW-1:0]              parent,
    output logic [gspt_pkg::HOP_W-1:0] hop
);
    import gspt_pkg::*;

    logic              mark_reg;
    logic              mark_next;
    logic [VW-1:0]     parent_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic              is_start;
    logic              wr_en;

    assign is_start = (vtx == VW'(LANE_ID));
    assign fresh    = row_bit & ~mark_reg;
    assign wr_en    = (ctl.init && is_start) || (ctl.scan && fresh);

    // mark is set when the vertex is pushed
    always_comb
    begin
        mark_next = mark_reg;
        if (ctl.init)
        begin
            mark_next = is_start;
        end
        else if (ctl.scan && fresh)
        begin
            mark_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    // tree entry: parent and hop count
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_reg <= vtx;
            hop_reg    <= hop_wr;
        end
    end

    assign mark   = mark_reg;
    assign parent = parent_reg;
    assign hop    = hop_reg;

endmodule

[hdl/gspt_pick.sv]
// ----------------------------------------------------------------------------
// gspt_pick: lane merge encoder
// Returns the index of the highest request bit and whether any bit is set.
// ----------------------------------------------------------------------------
module gspt_pick #(
    parameter int N = 16
) (
    input  logic [N-1:0]         req,
    output logic [$clog2(N)-1:0] idx,
    output logic                 any
);

    localparam int IW = $clog2(N);

    // higher lanes override lower ones
    always_comb
    begin
        idx = '0;
        for (int j = 0; j < N; j++)
        begin
            if (req[j])
            begin
                idx = IW'(j);
            end
        end
    end

    assign any = |req;

endmodule

[hdl/graph_search_path_trace.sv]
// ----------------------------------------------------------------------------
// graph_search_path_trace: stack-ordered graph search with parent path trace
// Loads adjacency rows, searches from a start vertex and streams the path.
// ----------------------------------------------------------------------------
// Usage:
//   item / item_valid / item_ready carry one command beat. Opcode load writes
//   one adjacency row and gives no result. Opcode search runs a depth-first
//   traversal from start_vertex, then streams the tree path start..end_vertex
//   on result / result_valid / result_ready, one beat per vertex, last set on
//   the end vertex. An unreachable end, or a start or end out of range, gives
//   one beat with reachable clear.
// Timing:
//   Every vertex in the search is popped once: a pick state plus a row scan
//   in the vertex lanes, plus a pop state each time an exhausted neighbor
//   group is refilled from the frame stack RAM. Then the trace state walks
//   the parents of the path vertices, then the path streams out one beat per
//   cycle while result_ready stays high. The pick/scan loop through the
//   adjacency RAM read port sets the rate of the search. item_ready is high
//   only while idle; one search is in flight at a time.
// Reset clears all adjacency rows (row valid bits), marks and the stack.
// A stalled receiver holds the result register and halts the path stream;
// the next command is taken while the final beat still waits.
// ----------------------------------------------------------------------------
module graph_search_path_trace #(
    parameter int VERTICES = gspt_pkg::VERTICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  gspt_pkg::in_beat_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output gspt_pkg::out_beat_t result
);
    import gspt_pkg::*;

    localparam int VW = $clog2(VERTICES);
    localparam int DW = $clog2(VERTICES + 1);
    localparam int FW = VERTICES + HOP_W;
    localparam int XW = (VERTICES > ROW_W) ? VERTICES : ROW_W;

    // registers
    state_t              state_reg,  state_next;
    logic [VERTICES-1:0] top_mask_reg, top_mask_next;
    logic [HOP_W-1:0]    top_hop_reg, top_hop_next;
    logic [DW-1:0]       fdepth_reg, fdepth_next;
    logic [VW-1:0]       cur_reg, cur_next;
    logic [VERTICES-1:0] rest_reg, rest_next;
    logic [HOP_W-1:0]    cur_hop_reg, cur_hop_next;
    logic                row_ok_reg, row_ok_next;
    logic [VERTICES-1:0] adj_vld_reg, adj_vld_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [VW-1:0]       start_reg, start_next;
    logic [VW-1:0]       end_reg, end_next;
    logic [VERTICES-1:0] onpath_reg, onpath_next;
    logic [HOP_W-1:0]    hop_end_reg, hop_end_next;
    logic [VW-1:0]       emit_v_reg, emit_v_next;
    logic                miss_reg, miss_next;
    logic                result_valid_reg, result_valid_next;
    out_beat_t           result_reg, result_next;

    // datapath wires
    logic                item_acc;
    logic                row_in_range;
    logic                ends_in_range;
    logic [XW-1:0]       row_ext;
    logic [VERTICES-1:0] adj_rdata;
    logic [VERTICES-1:0] row_eff;
    logic [FW-1:0]       frame_rdata;
    logic [DW-1:0]       fdepth_dec;
    logic                adj_wr_en;
    logic                frm_wr_en;
    logic                frm_rd_en;
    logic [VW-1:0]       pick_idx;
    logic                pick_any;
    logic [VW-1:0]       next_v;
    logic                next_any;
    logic [VERTICES-1:0] match_w;
    logic [VERTICES-1:0] mark_w;
    logic [VERTICES-1:0] new_w;
    logic [VW-1:0]       parent_w [VERTICES];
    logic [HOP_W-1:0]    hop_w [VERTICES];
    lane_ctl_t           lane_ctl;
    logic [VW-1:0]       lane_vtx;
    logic [HOP_W-1:0]    lane_hop;
    logic                new_any;
    logic                rest_any;

    assign item_ready    = (state_reg == ST_IDLE);
    assign item_acc      = item_valid && item_ready;
    assign row_in_range  = (32'(item.row_index) < VERTICES);
    assign ends_in_range = (32'(item.start_vertex) < VERTICES)
                        && (32'(item.end_vertex) < VERTICES);
    assign row_ext       = XW'(item.row_bits);
    assign row_eff       = adj_rdata & {VERTICES{row_ok_reg}};
    assign fdepth_dec    = fdepth_reg - DW'(1);
    assign new_any       = |new_w;
    assign rest_any      = |rest_reg;

    // adjacency row store
    assign adj_wr_en = item_acc && (item.opcode == OP_LOAD) && row_in_range;

    gspt_ram #(
        .WIDTH (VERTICES),
        .DEPTH (VERTICES)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (adj_wr_en),
        .wr_addr (VW'(item.row_index)),
        .wr_data (row_ext[VERTICES-1:0]),
        .rd_en   (state_reg == ST_PICK),
        .rd_addr (pick_idx),
        .rd_data (adj_rdata)
    );

    // frame stack: neighbor groups waiting below the top group
    assign frm_wr_en = (state_reg == ST_SCAN) && new_any && rest_any;
    assign frm_rd_en = (state_reg == ST_SCAN) && !new_any && !rest_any
                    && (fdepth_reg != '0);

    gspt_ram #(
        .WIDTH (FW),
        .DEPTH (VERTICES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frm_wr_en),
        .wr_addr (fdepth_reg[VW-1:0]),
        .wr_data ({rest_reg, cur_hop_reg}),
        .rd_en   (frm_rd_en),
        .rd_addr (fdepth_dec[VW-1:0]),
        .rd_data (frame_rdata)
    );

    // vertex lanes
    assign lane_ctl.init = item_acc && (item.opcode == OP_SEARCH) && ends_in_range;
    assign lane_ctl.scan = (state_reg == ST_SCAN);
    assign lane_vtx      = lane_ctl.init ? VW'(item.start_vertex) : cur_reg;
    assign lane_hop      = lane_ctl.init ? '0 : (cur_hop_reg + HOP_W'(1));

    for (genvar g = 0; g < VERTICES; g++)
    begin : g_lane
        gspt_lane #(
            .VW      (VW),
            .LANE_ID (g)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (lane_ctl),
            .vtx     (lane_vtx),
            .hop_wr  (lane_hop),
            .row_bit (row_eff[g]),
            .mark    (mark_w[g]),
            .fresh   (new_w[g]),
            .parent  (parent_w[g]),
            .hop     (hop_w[g])
        );
    end

    // child of the emitted vertex on the path
    always_comb
    begin
        for (int j = 0; j < VERTICES; j++)
        begin
            match_w[j] = onpath_reg[j] && (parent_w[j] == emit_v_reg);
        end
    end

    gspt_pick #(.N(VERTICES)) u_pick_cur (
        .req (top_mask_reg),
        .idx (pick_idx),
        .any (pick_any)
    );

    gspt_pick #(.N(VERTICES)) u_pick_next (
        .req (match_w),
        .idx (next_v),
        .any (next_any)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        top_mask_next     = top_mask_reg;
        top_hop_next      = top_hop_reg;
        fdepth_next       = fdepth_reg;
        cur_next          = cur_reg;
        rest_next         = rest_reg;
        cur_hop_next      = cur_hop_reg;
        row_ok_next       = row_ok_reg;
        adj_vld_next      = adj_vld_reg;
        v_next            = v_reg;
        start_next        = start_reg;
        end_next          = end_reg;
        onpath_next       = onpath_reg;
        hop_end_next      = hop_end_reg;
        emit_v_next       = emit_v_reg;
        miss_next         = miss_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        if (adj_wr_en)
        begin
            adj_vld_next[VW'(item.row_index)] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.opcode == OP_SEARCH))
                begin
                    start_next = VW'(item.start_vertex);
                    end_next   = VW'(item.end_vertex);
                    if (ends_in_range)
                    begin
                        top_mask_next = VERTICES'(1) << VW'(item.start_vertex);
                        top_hop_next  = '0;
                        fdepth_next   = '0;
                        miss_next     = 1'b0;
                        state_next    = ST_PICK;
                    end
                    else
                    begin
                        miss_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_PICK:
            begin
                // pop the highest vertex of the top group
                cur_next     = pick_idx;
                rest_next    = top_mask_reg & ~(VERTICES'(1) << pick_idx);
                cur_hop_next = top_hop_reg;
                row_ok_next  = adj_vld_reg[pick_idx];
                state_next   = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (new_any)
                begin
                    // fresh neighbors become the new top group
                    if (rest_any)
                    begin
                        fdepth_next = fdepth_reg + DW'(1);
                    end
                    top_mask_next = new_w;
                    top_hop_next  = cur_hop_reg + HOP_W'(1);
                    state_next    = ST_PICK;
                end
                else if (rest_any)
                begin
                    top_mask_next = rest_reg;
                    top_hop_next  = cur_hop_reg;
                    state_next    = ST_PICK;
                end
                else if (fdepth_reg != '0)
                begin
                    fdepth_next = fdepth_dec;
                    state_next  = ST_POP;
                end
                else if (mark_w[end_reg])
                begin
                    // search done, end reached
                    v_next       = end_reg;
                    onpath_next  = '0;
                    hop_end_next = hop_w[end_reg];
                    state_next   = ST_TRACE;
                end
                else
                begin
                    miss_next  = 1'b1;
                    state_next = ST_EMIT;
                end
            end

            ST_POP:
            begin
                top_mask_next = frame_rdata[FW-1:HOP_W];
                top_hop_next  = frame_rdata[HOP_W-1:0];
                state_next    = ST_PICK;
            end

            ST_TRACE:
            begin
                // walk parents from end back to start, marking the path
                if (v_reg == start_reg)
                begin
                    emit_v_next = start_reg;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    onpath_next = onpath_reg | (VERTICES'(1) << v_reg);
                    v_next      = parent_w[v_reg];
                end
            end

            ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    if (miss_reg)
                    begin
                        result_next.path_vertex = '0;
                        result_next.hop_count   = '0;
                        result_next.reachable   = 1'b0;
                        result_next.last        = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        result_next.path_vertex = VIDX_W'(emit_v_reg);
                        result_next.hop_count   = hop_end_reg;
                        result_next.reachable   = 1'b1;
                        result_next.last        = (emit_v_reg == end_reg);
                        if (emit_v_reg == end_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            emit_v_next = next_v;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fdepth_reg       <= '0;
            adj_vld_reg      <= '0;
            miss_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fdepth_reg       <= fdepth_next;
            adj_vld_reg      <= adj_vld_next;
            miss_reg         <= miss_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_mask_reg <= top_mask_next;
        top_hop_reg  <= top_hop_next;
        cur_reg      <= cur_next;
        rest_reg     <= rest_next;
        cur_hop_reg  <= cur_hop_next;
        row_ok_reg   <= row_ok_next;
        v_reg        <= v_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        onpath_reg   <= onpath_next;
        hop_end_reg  <= hop_end_next;
        emit_v_reg   <= emit_v_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> (pick_any && top_mask_reg != '0))
        else $error("pick with empty top group");

    a_top_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> ((top_mask_reg & ~mark_w) == '0))
        else $error("stacked vertex not marked");

    a_frame_depth: assert property (@(posedge clk) disable iff (!rst_n)
        fdepth_reg < DW'(VERTICES))
        else $error("frame stack overflow");

    a_path_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !miss_reg && emit_v_reg != end_reg
            && (!result_valid_reg || result_ready)) |-> next_any)
        else $error("path child missing");

endmodule

[bench/graph_search_path_trace_tb.sv]
// ----------------------------------------------------------------------------
// graph_search_path_trace_tb: self-checking bench for the path tracer
// Loads adjacency rows and issues searches under random backpressure on both
// channels. A scoreboard class keeps its own copy of the matrix, repeats the
// stack-ordered search per search beat and checks each result beat in order.
// ----------------------------------------------------------------------------
module graph_search_path_trace_tb;

    import gspt_pkg::*;

    localparam int NV          = VERTICES_DEF;
    localparam int RAND_ITEMS  = 400;
    localparam int CALM_AFTER  = 330;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1000000;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow adjacency matrix, search predictor, expected beats
    // ------------------------------------------------------------------------
    class path_scoreboard;
        logic [ROW_W-1:0] adj_rows [NV];
        out_beat_t        path_q [$];
        int               errors;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            errors = 0;
        endfunction

        function int pending();
            return path_q.size();
        endfunction

        // append one expected beat at the tail
        function void add_expected(out_beat_t b);
            path_q.insert(path_q.size(), b);
        endfunction

        // one accepted command beat: update the matrix or queue the path
        function void note_item(in_beat_t b);
            logic [NV-1:0]     marks;
            logic [VIDX_W-1:0] parent [NV];
            logic [HOP_W-1:0]  hops [NV];
            logic [VIDX_W-1:0] stack [NV];
            logic [VIDX_W-1:0] chain [NV];
            logic [VIDX_W-1:0] cur;
            logic [VIDX_W-1:0] v;
            int                level;
            int                len;
            int                j;
            out_beat_t         r;

            if (b.opcode == OP_LOAD) begin
                if (int'(b.row_index) < NV)
                    adj_rows[b.row_index] = b.row_bits;
                return;
            end

            r = '0;
            r.last = 1'b1;
            if (int'(b.start_vertex) >= NV || int'(b.end_vertex) >= NV) begin
                add_expected(r);
                return;
            end

            // stack-ordered search, a vertex is marked when pushed
            marks = '0;
            stack[0] = b.start_vertex;
            level = 1;
            marks[b.start_vertex] = 1'b1;
            hops[b.start_vertex] = '0;
            parent[b.start_vertex] = b.start_vertex;
            while (level > 0) begin
                level--;
                cur = stack[level];
                for (j = 0; j < NV; j++) begin
                    if (!marks[j] && adj_rows[cur][j]) begin
                        if (level < NV) begin
                            stack[level] = j[VIDX_W-1:0];
                            level++;
                        end
                        marks[j] = 1'b1;
                        hops[j] = hops[cur] + 1'b1;
                        parent[j] = cur;
                    end
                end
            end

            // unreachable end: single beat with reachable clear
            if (!marks[b.end_vertex]) begin
                add_expected(r);
                return;
            end

            // walk parents back from the end; never longer than NV vertices
            len = 0;
            v = b.end_vertex;
            while (len < NV) begin
                chain[len] = v;
                len++;
                if (v == b.start_vertex)
                    break;
                v = parent[v];
            end

            for (j = len; j > 0; j--) begin
                r.path_vertex = chain[j-1];
                r.hop_count   = hops[b.end_vertex];
                r.reachable   = 1'b1;
                r.last        = (j == 1);
                add_expected(r);
            end
        endfunction

        // one accepted result beat against the oldest expectation
        function void check_result(out_beat_t got);
            out_beat_t want;
            if (path_q.size() == 0) begin
                $error("unexpected result beat: path_vertex %0d last %0d",
                       got.path_vertex, got.last);
                errors++;
                return;
            end
            want = path_q.pop_front();
            if (got.path_vertex !== want.path_vertex) begin
                $error("path_vertex: expected %0d, actual %0d",
                       want.path_vertex, got.path_vertex);
                errors++;
            end
            if (got.hop_count !== want.hop_count) begin
                $error("hop_count: expected %0d, actual %0d",
                       want.hop_count, got.hop_count);
                errors++;
            end
            if (got.reachable !== want.reachable) begin
                $error("reachable: expected %0d, actual %0d",
                       want.reachable, got.reachable);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_beat_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_beat_t result;

    path_scoreboard sb = new();
    bit             calm = 1'b0;
    int             sent = 0;
    int             cycle_count = 0;

    always #2 clk = ~clk;

    graph_search_path_trace i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // receiver: random stall bursts, none once calm
    initial begin : sink_ready
        while (!rst_n) @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    function automatic in_beat_t load_beat(int row, logic [ROW_W-1:0] bits);
        in_beat_t b;
        b.opcode       = OP_LOAD;
        b.row_index    = row[VIDX_W-1:0];
        b.row_bits     = bits;
        b.start_vertex = VIDX_W'($urandom_range(0, 15));
        b.end_vertex   = VIDX_W'($urandom_range(0, 15));
        return b;
    endfunction

    function automatic in_beat_t search_beat(int s, int e);
        in_beat_t b;
        b.opcode       = OP_SEARCH;
        b.row_index    = VIDX_W'($urandom_range(0, 15));
        b.row_bits     = ROW_W'($urandom);
        b.start_vertex = s[VIDX_W-1:0];
        b.end_vertex   = e[VIDX_W-1:0];
        return b;
    endfunction

    // entered and left on a rising edge; valid stays high on return
    task automatic send_beat(in_beat_t b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= b;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        sb.note_item(b);
        sent++;
    endtask

    // hold off the sender until every queued path beat has come back
    task automatic drain_paths();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // random row content for one scene style
    function automatic logic [ROW_W-1:0] scene_row(int style);
        case (style)
            0:       return ROW_W'($urandom);
            1:       return ROW_W'($urandom & $urandom & $urandom);
            default: return (16'h1 << $urandom_range(0, 15)) |
                            (($urandom_range(0, 3) == 0) ?
                             (16'h1 << $urandom_range(0, 15)) : 16'h0);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int order [NV];
        int style;
        int nrows;
        int nsearch;
        int k;
        int t;
        int sw;
        logic [ROW_W-1:0] bits;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty graph: start equals end, then an unreachable end
        send_beat(search_beat(0, 0));
        send_beat(search_beat(3, 9));

        // straight chain 0..15 gives the longest path
        for (k = 0; k < NV; k++)
            send_beat(load_beat(k, (k < NV - 1) ? (16'h1 << (k + 1)) : 16'h0));
        send_beat(search_beat(0, 15));
        send_beat(search_beat(15, 0));
        drain_paths();

        // full row with self loop on the last vertex
        send_beat(load_beat(15, 16'hFFFF));
        send_beat(search_beat(15, 0));
        send_beat(search_beat(7, 7));

        // diamond: the later push is popped first and claims the shared child
        send_beat(load_beat(0, 16'h0006));
        send_beat(load_beat(1, 16'h0008));
        send_beat(load_beat(2, 16'h0008));
        send_beat(search_beat(0, 3));
        send_beat(load_beat(4, 16'h0000));
        drain_paths();

        // random scenes: load part or all of the matrix, then a few searches
        while (sent < RAND_ITEMS) begin
            style = $urandom_range(0, 3);
            for (k = 0; k < NV; k++)
                order[k] = k;
            for (k = NV - 1; k > 0; k--) begin
                sw = $urandom_range(0, k);
                t = order[k];
                order[k] = order[sw];
                order[sw] = t;
            end

            if (style == 3) begin
                // random Hamiltonian chain with some side edges: deep paths
                for (k = 0; k < NV; k++) begin
                    bits = (k < NV - 1) ? (16'h1 << order[k + 1]) : 16'h0;
                    if ($urandom_range(0, 3) == 0)
                        bits |= 16'h1 << $urandom_range(0, 15);
                    send_beat(load_beat(order[k], bits));
                end
            end else begin
                nrows = ($urandom_range(0, 3) == 0) ? NV : $urandom_range(0, 6);
                for (k = 0; k < nrows; k++)
                    send_beat(load_beat(order[k], scene_row(style)));
            end

            nsearch = $urandom_range(1, 5);
            for (k = 0; k < nsearch; k++) begin
                if (style == 3 && $urandom_range(0, 1) == 0)
                    send_beat(search_beat(order[0], $urandom_range(0, 15)));
                else
                    send_beat(search_beat($urandom_range(0, 15),
                                          $urandom_range(0, 15)));
            end

            if (!calm && $urandom_range(0, 9) == 0)
                drain_paths();
            if (sent >= CALM_AFTER)
                calm = 1'b1;
        end

        // wait out the last paths, then a quiet tail for stray beats
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/gspt_pkg.sv
hdl/gspt_ram.sv
hdl/gspt_lane.sv
hdl/gspt_pick.sv
hdl/graph_search_path_trace.sv
bench/graph_search_path_trace_tb.sv
